/* rtl/bdd_pkg.sv */
// bdd_pkg: shared widths, operation codes and status codes of the bounded deque
// with duplicate removal. No dependencies.
`timescale 1ns / 1ps

package bdd_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // operation codes carried by s_mode
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEDUP      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ_POS   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

/* rtl/bdd_ram.sv */
// bdd_ram: generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bdd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/bounded_deque_with_dedup.sv */
// bounded_deque_with_dedup: top level of the bounded deque with duplicate removal.
// Depends on bdd_pkg and bdd_ram.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values kept as a ring in one
// synchronous RAM of CAPACITY entries, one request at a time, one result per
// request. Pushes, the spare operation codes and every request that ends in an
// error status give their result in the cycle after acceptance; pops and position
// reads pass through S_READ first, since the RAM read is registered. Dedup
// walks the live entries through the single read port: for each entry it
// fetches the entry, then compares it against each surviving value already
// kept. A new request is taken only when the result register is empty or
// is read out in the same cycle, so a result left waiting on m_ready holds
// off the input.
// The store needs no clearing after reset; only the live region is ever read.

module bounded_deque_with_dedup
    import bdd_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [MODE_W-1:0]          s_mode,
    input  logic signed [DATA_W-1:0]   s_operand,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_data,
    output logic [COUNT_W-1:0]         m_count
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W:0]   CAP_X    = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_READ    = 4'b0010,
        S_DD_CAND = 4'b0100,
        S_DD_SCAN = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      i_reg, i_next;
    logic [CNT_W-1:0]      w_reg, w_next;
    logic [CNT_W-1:0]      j_reg, j_next;
    logic [DATA_W-1:0]     cand_reg, cand_next;

    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [DATA_W-1:0]     m_data_reg, m_data_next;
    logic [COUNT_W-1:0]    m_count_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [DATA_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [DATA_W-1:0]     ram_rdata;

    logic                  accept;
    logic                  out_load;
    logic                  is_full;
    logic                  is_empty;
    logic                  pos_ok;
    logic [DATA_W-1:0]     pos_m1;
    logic [CNT_W-1:0]      i_inc;
    logic [CNT_W-1:0]      count_m1;

    // ring slot of an offset from the front
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= CAP_X) begin
            sum = sum - CAP_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    bdd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // handshake: take a request when idle and the result register is free
    assign s_ready  = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg >= CNT_FULL);
    assign is_empty = (count_reg == '0);
    assign count_m1 = count_reg - 1'b1;
    assign i_inc    = i_reg + 1'b1;

    // 1-based position check against the current count
    assign pos_m1 = s_operand - 32'sd1;
    assign pos_ok = !s_operand[DATA_W-1] && (s_operand != '0)
                    && (s_operand[DATA_W-2:0] <= (DATA_W - 1)'(count_reg));

    // request decode, memory sequencing and dedup walk
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        w_next        = w_reg;
        j_next        = j_reg;
        cand_next     = cand_reg;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_wdata     = s_operand;
        ram_raddr     = head_reg;
        out_load      = 1'b0;
        m_status_next = ST_OK;
        m_data_next   = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_PUSH_FRONT: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                head_next  = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
                                ram_we     = 1'b1;
                                ram_waddr  = head_next;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            out_load = 1'b1;
                            if (is_full) begin
                                m_status_next = ST_FULL;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_of(head_reg, count_reg[IDX_W-1:0]);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (is_empty) begin
                                out_load      = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                ram_raddr  = head_reg;
                                head_next  = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
                                count_next = count_m1;
                                state_next = S_READ;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (is_empty) begin
                                out_load      = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                ram_raddr  = slot_of(head_reg, count_m1[IDX_W-1:0]);
                                count_next = count_m1;
                                state_next = S_READ;
                            end
                        end
                        MODE_DEDUP: begin
                            if (is_empty) begin
                                out_load      = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else begin
                                i_next     = '0;
                                w_next     = '0;
                                ram_raddr  = head_reg;
                                state_next = S_DD_CAND;
                            end
                        end
                        MODE_READ_POS: begin
                            if (is_empty) begin
                                out_load      = 1'b1;
                                m_status_next = ST_EMPTY;
                            end else if (!pos_ok) begin
                                out_load      = 1'b1;
                                m_status_next = ST_RANGE;
                            end else begin
                                ram_raddr  = slot_of(head_reg, pos_m1[IDX_W-1:0]);
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end

            // read data of a pop or position read is back
            S_READ: begin
                out_load    = 1'b1;
                m_data_next = ram_rdata;
                state_next  = S_IDLE;
            end

            // candidate value is back; nothing kept yet means it survives
            S_DD_CAND: begin
                if (w_reg == '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = slot_of(head_reg, w_reg[IDX_W-1:0]);
                    ram_wdata = ram_rdata;
                    w_next    = w_reg + 1'b1;
                    if (i_inc == count_reg) begin
                        count_next = w_next;
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_inc;
                        ram_raddr  = slot_of(head_reg, i_inc[IDX_W-1:0]);
                        state_next = S_DD_CAND;
                    end
                end else begin
                    cand_next  = ram_rdata;
                    j_next     = '0;
                    ram_raddr  = head_reg;
                    state_next = S_DD_SCAN;
                end
            end

            // compare candidate with kept value j, fetching j+1 meanwhile
            S_DD_SCAN: begin
                if ((ram_rdata == cand_reg) || (j_reg == w_reg - 1'b1)) begin
                    if (ram_rdata != cand_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = slot_of(head_reg, w_reg[IDX_W-1:0]);
                        ram_wdata = cand_reg;
                        w_next    = w_reg + 1'b1;
                    end
                    if (i_inc == count_reg) begin
                        count_next = w_next;
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_inc;
                        ram_raddr  = slot_of(head_reg, i_inc[IDX_W-1:0]);
                        state_next = S_DD_CAND;
                    end
                end else begin
                    j_next    = j_reg + 1'b1;
                    ram_raddr = slot_of(head_reg, j_next[IDX_W-1:0]);
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register valid flag
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // walk counters and result payload
    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        w_reg    <= w_next;
        j_reg    <= j_next;
        cand_reg <= cand_next;
        if (out_load) begin
            m_status_reg <= m_status_next;
            m_data_reg   <= m_data_next;
            m_count_reg  <= COUNT_W'(count_next);
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_data   = $signed(m_data_reg);
    assign m_count  = m_count_reg;

`ifndef SYNTHESIS
    // the entry count never exceeds the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    // any request still in the memory path finds the result register empty
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_valid_reg)
        else $error("result register busy while a request is in progress");

    // an error result carries zero data
    a_err_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_data == '0))
        else $error("non-zero data with error status");

    // a push that is not rejected adds exactly one entry
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_full && ((s_mode == MODE_PUSH_FRONT) || (s_mode == MODE_PUSH_BACK)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not add one entry");

    // during dedup the write pointer never passes the read pointer
    a_dedup_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DD_CAND) || (state_reg == S_DD_SCAN))
        |-> ((w_reg <= i_reg) && (i_reg < count_reg)))
        else $error("dedup pointers out of order");
`endif

endmodule
